### rtl/i2cbm_pkg.sv
`timescale 1ns / 1ps

package i2cbm_pkg;

  localparam int TIMEOUT_BITS = 20;
  localparam logic [TIMEOUT_BITS-1:0] ACK_TIMEOUT_RESET = TIMEOUT_BITS'(300000);
  localparam int QUEUE_DEPTH = 2;

  // Command codes match the opcode encoding on the input channel.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_RACK  = 3'd4,
    CMD_RNACK = 3'd5
  } cmd_t;

  // Phase of the active command; start and stop use only the first three.
  typedef enum logic [2:0] {
    PH_BIT_SET  = 3'd0,
    PH_BIT_HIGH = 3'd1,
    PH_BIT_LOW  = 3'd2,
    PH_ACK_SET  = 3'd3,
    PH_ACK_HIGH = 3'd4,
    PH_ACK_WAIT = 3'd5,
    PH_ACK_HOLD = 3'd6
  } phase_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_en;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       status;
  } out_item_t;

  // Classified tick handed from the front to the engine.
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       sda_sample;
  } tick_t;

endpackage

### rtl/i2cbm_front.sv
`timescale 1ns / 1ps

module i2cbm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  i2cbm_pkg::in_item_t in_item,
  output logic                tick_valid,
  output i2cbm_pkg::tick_t    tick,
  input  logic                tick_take
);

  i2cbm_pkg::tick_t  entry_r [i2cbm_pkg::QUEUE_DEPTH];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  i2cbm_pkg::tick_t  classified;
  logic              do_push, do_pop;

  // Opcodes outside the command set are carried as plain idle ticks.
  always_comb begin
    classified.tx_byte    = in_item.tx_byte;
    classified.sda_sample = in_item.sda_sample;
    case (in_item.opcode)
      i2cbm_pkg::CMD_START: classified.cmd = i2cbm_pkg::CMD_START;
      i2cbm_pkg::CMD_STOP:  classified.cmd = i2cbm_pkg::CMD_STOP;
      i2cbm_pkg::CMD_WRITE: classified.cmd = i2cbm_pkg::CMD_WRITE;
      i2cbm_pkg::CMD_RACK:  classified.cmd = i2cbm_pkg::CMD_RACK;
      i2cbm_pkg::CMD_RNACK: classified.cmd = i2cbm_pkg::CMD_RNACK;
      default:              classified.cmd = i2cbm_pkg::CMD_NONE;
    endcase
  end

  assign full       = (count_r == 2'(i2cbm_pkg::QUEUE_DEPTH));
  assign tick_valid = (count_r != 2'd0);
  assign tick       = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = tick_take && tick_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= classified;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(i2cbm_pkg::QUEUE_DEPTH))
    else $error("front queue count overflow");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("front queue pointers disagree with count");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !tick_take) |=> full)
    else $error("front queue lost an entry without a take");
`endif

endmodule

### rtl/i2cbm_back.sv
`timescale 1ns / 1ps

module i2cbm_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [i2cbm_pkg::TIMEOUT_BITS-1:0]   cfg_wdata,
  input  logic                                 tick_valid,
  input  i2cbm_pkg::tick_t                     tick,
  output logic                                 tick_take,
  output logic                                 empty,
  input  logic                                 pop,
  output i2cbm_pkg::out_item_t                 out_item
);

  localparam int TB = i2cbm_pkg::TIMEOUT_BITS;

  logic [TB-1:0]      timeout_r;
  i2cbm_pkg::cmd_t    active_cmd_r, active_cmd_nxt;
  i2cbm_pkg::phase_t  phase_r, phase_nxt;
  logic [3:0]         bit_count_r, bit_count_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [TB-1:0]      wait_r, wait_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic               sda_en_r, sda_en_nxt;
  logic [7:0]         rx_r, rx_nxt;
  logic               status_r, status_nxt;

  i2cbm_pkg::out_item_t res_entry_r [i2cbm_pkg::QUEUE_DEPTH];
  logic               res_wr_r, res_rd_r;
  logic [1:0]         res_count_r, res_count_nxt;
  i2cbm_pkg::out_item_t result;
  logic               go, do_pop;
  logic               starting, done;
  i2cbm_pkg::cmd_t    cmd;
  i2cbm_pkg::phase_t  phase;
  logic [3:0]         bit_count;
  logic [3:0]         bit_inc;
  logic [7:0]         shift;
  logic [TB-1:0]      wait_cnt;
  logic [TB-1:0]      limit;
  logic [TB:0]        wait_inc;

  assign go        = tick_valid && (res_count_r != 2'(i2cbm_pkg::QUEUE_DEPTH));
  assign tick_take = go;
  assign do_pop    = pop && !empty;
  assign empty     = (res_count_r == 2'd0);
  assign out_item  = res_entry_r[res_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= i2cbm_pkg::ACK_TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // One bus tick of the bit engine.
  always_comb begin
    starting  = (active_cmd_r == i2cbm_pkg::CMD_NONE) && (tick.cmd != i2cbm_pkg::CMD_NONE);
    cmd       = starting ? tick.cmd : active_cmd_r;
    phase     = starting ? i2cbm_pkg::PH_BIT_SET : phase_r;
    bit_count = starting ? 4'd0 : bit_count_r;
    wait_cnt  = starting ? '0 : wait_r;
    shift     = starting ? ((tick.cmd == i2cbm_pkg::CMD_WRITE) ? tick.tx_byte : 8'd0)
                         : shift_r;
    bit_inc   = bit_count + 4'd1;
    limit     = (timeout_r == '0) ? TB'(1) : timeout_r;
    wait_inc  = {1'b0, wait_cnt} + {{TB{1'b0}}, 1'b1};

    active_cmd_nxt = cmd;
    phase_nxt      = phase;
    bit_count_nxt  = bit_count;
    shift_nxt      = shift;
    wait_nxt       = wait_cnt;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    sda_en_nxt     = sda_en_r;
    rx_nxt         = rx_r;
    status_nxt     = starting ? 1'b0 : status_r;
    done           = 1'b0;

    case (cmd)
      i2cbm_pkg::CMD_START: begin
        case (phase)
          i2cbm_pkg::PH_BIT_SET: begin
            sda_nxt = 1'b1; scl_nxt = 1'b1; sda_en_nxt = 1'b1;
            phase_nxt = i2cbm_pkg::PH_BIT_HIGH;
          end
          i2cbm_pkg::PH_BIT_HIGH: begin
            sda_nxt = 1'b0; phase_nxt = i2cbm_pkg::PH_BIT_LOW;
          end
          default: begin
            scl_nxt = 1'b0; done = 1'b1;
          end
        endcase
      end
      i2cbm_pkg::CMD_STOP: begin
        case (phase)
          i2cbm_pkg::PH_BIT_SET: begin
            sda_nxt = 1'b0; sda_en_nxt = 1'b1; phase_nxt = i2cbm_pkg::PH_BIT_HIGH;
          end
          i2cbm_pkg::PH_BIT_HIGH: begin
            scl_nxt = 1'b1; phase_nxt = i2cbm_pkg::PH_BIT_LOW;
          end
          default: begin
            sda_nxt = 1'b1; done = 1'b1;
          end
        endcase
      end
      i2cbm_pkg::CMD_WRITE: begin
        case (phase)
          i2cbm_pkg::PH_BIT_SET: begin
            sda_nxt = shift[7]; sda_en_nxt = 1'b1;
            shift_nxt = {shift[6:0], 1'b0};
            phase_nxt = i2cbm_pkg::PH_BIT_HIGH;
          end
          i2cbm_pkg::PH_BIT_HIGH: begin
            scl_nxt = 1'b1; phase_nxt = i2cbm_pkg::PH_BIT_LOW;
          end
          i2cbm_pkg::PH_BIT_LOW: begin
            scl_nxt = 1'b0; bit_count_nxt = bit_inc;
            phase_nxt = (bit_inc >= 4'd8) ? i2cbm_pkg::PH_ACK_SET : i2cbm_pkg::PH_BIT_SET;
          end
          i2cbm_pkg::PH_ACK_SET: begin
            sda_en_nxt = 1'b0; phase_nxt = i2cbm_pkg::PH_ACK_HIGH;
          end
          i2cbm_pkg::PH_ACK_HIGH: begin
            scl_nxt = 1'b1; phase_nxt = i2cbm_pkg::PH_ACK_WAIT;
          end
          default: begin
            if (!tick.sda_sample) begin
              scl_nxt = 1'b0; sda_en_nxt = 1'b1; done = 1'b1;
            end else if (wait_inc >= {1'b0, limit}) begin
              // The slave never acknowledged: release the bus and flag it.
              sda_en_nxt = 1'b1; sda_nxt = 1'b1; scl_nxt = 1'b0;
              status_nxt = 1'b1; done = 1'b1;
            end else begin
              wait_nxt = wait_inc[TB-1:0];
            end
          end
        endcase
      end
      i2cbm_pkg::CMD_RACK, i2cbm_pkg::CMD_RNACK: begin
        case (phase)
          i2cbm_pkg::PH_BIT_SET: begin
            sda_en_nxt = 1'b0; scl_nxt = 1'b1; phase_nxt = i2cbm_pkg::PH_BIT_HIGH;
          end
          i2cbm_pkg::PH_BIT_HIGH: begin
            shift_nxt = {shift[6:0], tick.sda_sample};
            phase_nxt = i2cbm_pkg::PH_BIT_LOW;
          end
          i2cbm_pkg::PH_BIT_LOW: begin
            scl_nxt = 1'b0; bit_count_nxt = bit_inc;
            if (bit_inc >= 4'd8) begin
              rx_nxt = shift; phase_nxt = i2cbm_pkg::PH_ACK_SET;
            end else begin
              phase_nxt = i2cbm_pkg::PH_BIT_SET;
            end
          end
          i2cbm_pkg::PH_ACK_SET: begin
            sda_en_nxt = 1'b1;
            sda_nxt = (cmd == i2cbm_pkg::CMD_RACK) ? 1'b0 : 1'b1;
            phase_nxt = i2cbm_pkg::PH_ACK_HIGH;
          end
          i2cbm_pkg::PH_ACK_HIGH: begin
            scl_nxt = 1'b1; phase_nxt = i2cbm_pkg::PH_ACK_WAIT;
          end
          default: begin
            if ((phase == i2cbm_pkg::PH_ACK_WAIT) && (cmd == i2cbm_pkg::CMD_RACK)) begin
              phase_nxt = i2cbm_pkg::PH_ACK_HOLD;
            end else begin
              scl_nxt = 1'b0; done = 1'b1;
            end
          end
        endcase
      end
      default: begin
      end
    endcase

    result.scl_level    = scl_nxt;
    result.sda_level    = sda_nxt;
    result.sda_drive_en = sda_en_nxt;
    result.busy_res     = (cmd != i2cbm_pkg::CMD_NONE);
    result.done_res     = done;
    result.rx_byte      = rx_nxt;
    result.status       = status_nxt;

    if (done) begin
      // A read leaves the SDA latch low once its final tick has been reported.
      if ((cmd == i2cbm_pkg::CMD_RACK) || (cmd == i2cbm_pkg::CMD_RNACK)) begin
        sda_nxt = 1'b0;
      end
      active_cmd_nxt = i2cbm_pkg::CMD_NONE;
      phase_nxt      = i2cbm_pkg::PH_BIT_SET;
      bit_count_nxt  = 4'd0;
      wait_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_cmd_r <= i2cbm_pkg::CMD_NONE;
      phase_r      <= i2cbm_pkg::PH_BIT_SET;
      bit_count_r  <= 4'd0;
      shift_r      <= 8'd0;
      wait_r       <= '0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      sda_en_r     <= 1'b1;
      rx_r         <= 8'd0;
      status_r     <= 1'b0;
    end else if (go) begin
      active_cmd_r <= active_cmd_nxt;
      phase_r      <= phase_nxt;
      bit_count_r  <= bit_count_nxt;
      shift_r      <= shift_nxt;
      wait_r       <= wait_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      sda_en_r     <= sda_en_nxt;
      rx_r         <= rx_nxt;
      status_r     <= status_nxt;
    end
  end

  assign res_count_nxt = res_count_r + 2'(go) - 2'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r    <= 1'b0;
      res_rd_r    <= 1'b0;
      res_count_r <= 2'd0;
    end else begin
      res_wr_r    <= go ? ~res_wr_r : res_wr_r;
      res_rd_r    <= do_pop ? ~res_rd_r : res_rd_r;
      res_count_r <= res_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_entry_r[res_wr_r] <= result;
    end
  end

`ifndef SYNTHESIS
  a_done_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (go && result.done_res) |=> (active_cmd_r == i2cbm_pkg::CMD_NONE))
    else $error("engine stayed busy after a done tick");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (go && result.done_res) |-> result.busy_res)
    else $error("done reported outside a command");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (active_cmd_r == i2cbm_pkg::CMD_NONE) |->
      ((phase_r == i2cbm_pkg::PH_BIT_SET) && (bit_count_r == 4'd0) && (wait_r == '0)))
    else $error("idle engine holds stale sequencing state");

  a_status_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(status_r) |-> ($past(active_cmd_r) == i2cbm_pkg::CMD_WRITE))
    else $error("timeout status set outside a write");

  a_wait_polling: assert property (@(posedge clk) disable iff (!rst_n)
    (wait_r != '0) |->
      ((active_cmd_r == i2cbm_pkg::CMD_WRITE) && (phase_r == i2cbm_pkg::PH_ACK_WAIT)))
    else $error("acknowledge wait count held outside the acknowledge poll");
`endif

endmodule

### rtl/i2c_bit_level_master_unit.sv
`timescale 1ns / 1ps

// I2C master bit engine. Each item pushed in is one bus tick and may carry a
// command (start, stop, write byte, read byte with ack or nack); exactly one
// result item comes out per input item, giving the SCL/SDA drive for that tick
// plus busy, done, the last received byte and the acknowledge timeout status.
// The engine advances at most one phase per tick, so the block sustains one
// item per clock cycle while the result queue is not full; each item passes
// through the input queue and then the engine into the result queue. Commands
// that arrive while a sequence runs are ignored. Write the acknowledge timeout
// only while no item is in flight.
module i2c_bit_level_master_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [i2cbm_pkg::TIMEOUT_BITS-1:0]   cfg_wdata,
  input  logic                                 push,
  output logic                                 full,
  input  i2cbm_pkg::in_item_t                  in_item,
  output logic                                 empty,
  input  logic                                 pop,
  output i2cbm_pkg::out_item_t                 out_item
);

  logic             tick_valid;
  logic             tick_take;
  i2cbm_pkg::tick_t tick;

  i2cbm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_take  (tick_take)
  );

  i2cbm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .tick_valid (tick_valid),
    .tick       (tick),
    .tick_take  (tick_take),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item)
  );

endmodule
